// ===== rtl/tgarle_pkg.sv =====
// Shared constants, register indexes and colour helpers for the TGA RLE pixel decoder.
// Depends on nothing; imported by tgarle_palette and tga_rle_pixel_decoder.

package tgarle_pkg;

    localparam int TGARLE_MAP_DEPTH = 256;

    // configuration register indexes
    localparam logic [2:0] REG_PIXEL_BYTES     = 3'd0;
    localparam logic [2:0] REG_RLE_ENABLE      = 3'd1;
    localparam logic [2:0] REG_INDEXED_ENABLE  = 3'd2;
    localparam logic [2:0] REG_MAP_LENGTH      = 3'd3;
    localparam logic [2:0] REG_MAP_ENTRY_BYTES = 3'd4;
    localparam logic [2:0] REG_PIXEL_TOTAL     = 3'd5;

    // decoder phases
    localparam logic [1:0] PH_PALETTE = 2'd0;
    localparam logic [1:0] PH_PIXELS  = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    localparam int ARGB_W = 32;

    typedef logic [ARGB_W-1:0] argb_t;

    // force a byte count into 1..4
    function automatic logic [2:0] clamp_count(input logic [2:0] n);
        logic [2:0] res;
        if (n == 3'd0) begin
            res = 3'd1;
        end else if (n > 3'd4) begin
            res = 3'd4;
        end else begin
            res = n;
        end
        return res;
    endfunction

    // convert n little-endian bytes (n already clamped) to ARGB
    function automatic argb_t to_argb(input logic [31:0] v, input logic [2:0] n);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [4:0] r5;
        logic [4:0] g5;
        logic [4:0] bl5;
        argb_t      res;
        b0  = v[7:0];
        b1  = v[15:8];
        b2  = v[23:16];
        b3  = v[31:24];
        r5  = b1[6:2];
        g5  = {b1[1:0], b0[7:5]};
        bl5 = b0[4:0];
        case (n)
            3'd1: begin
                res = {8'hFF, b0, b0, b0};
            end
            3'd2: begin
                res = {{8{b1[7]}}, r5, r5[4:2], g5, g5[4:2], bl5, bl5[4:2]};
            end
            3'd3: begin
                res = {8'hFF, b2, b1, b0};
            end
            default: begin
                res = {b3, b2, b1, b0};
            end
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/tgarle_palette.sv =====
// Palette store for the TGA RLE pixel decoder: one write port, one registered read port.
// Depends on tgarle_pkg for the colour word type.

module tgarle_palette
    import tgarle_pkg::*;
#(
    parameter int DEPTH = TGARLE_MAP_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  argb_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output argb_t         rd_data
);

    argb_t mem [DEPTH];
    argb_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tga_rle_pixel_decoder.sv =====
// Top level of the TGA RLE pixel decoder: byte assembly, packet control, palette lookup.
// Depends on tgarle_pkg and tgarle_palette.

// The decoder takes the image data of a Targa file one byte per word on the s_ channel.
// After a word with s_start_of_image set it loads map_length palette entries, then
// decodes pixel_total pixels, raw or run-length packetized, and gives one ARGB word per
// pixel or per run on the m_ channel, with a repeat count clipped to the pixels left.
// The s_ channel sustains one word per clock as long as the m_ side keeps up; the result
// for the byte that completes a pixel leaves the output register on the next cycle.
// The palette is a RAM of MAP_DEPTH entries with a registered read port, read in the
// same cycle that the completing index byte arrives.
// The palette is not cleared after reset: reading an entry that was never loaded gives
// arbitrary colour. Configuration writes take effect at once and must happen while idle.

module tga_rle_pixel_decoder
    import tgarle_pkg::*;
#(
    parameter int MAP_DEPTH = TGARLE_MAP_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_of_image,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_pixel_argb,
    output logic [7:0]  m_repeat_count,
    output logic        m_index_error,
    output logic        m_last_pixel
);

    localparam int AW = $clog2(MAP_DEPTH);

    // configuration registers
    logic [2:0]  pixel_bytes_reg;
    logic        rle_enable_reg;
    logic        indexed_enable_reg;
    logic [15:0] map_length_reg;
    logic [2:0]  map_entry_bytes_reg;
    logic [31:0] pixel_total_reg;

    // decoder state
    logic [1:0]  phase_reg,       phase_next;
    logic [23:0] byte_buffer_reg, byte_buffer_next;
    logic [1:0]  byte_pos_reg,    byte_pos_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_run_reg,  packet_run_next;
    logic [15:0] pal_wr_idx_reg,  pal_wr_idx_next;
    logic [31:0] pixels_left_reg, pixels_left_next;

    // output register
    logic        out_valid_reg,   out_valid_next;
    argb_t       colour_reg,      colour_next;
    logic [7:0]  rep_reg,         rep_next;
    logic        err_reg,         err_next;
    logic        last_reg,        last_next;
    logic        use_pal_reg,     use_pal_next;

    // step signals
    logic        s_fire;
    logic        load;
    logic        result;
    logic [1:0]  phase_e;
    logic [23:0] buf_e;
    logic [1:0]  pos_e;
    logic [7:0]  pleft_e;
    logic        prun_e;
    logic [15:0] pwi_e;
    logic [31:0] pixl_e;
    logic [2:0]  n_cnt;
    logic [31:0] gathered;
    logic        complete;
    logic [15:0] pwi_inc;
    logic        pal_wr_en;
    argb_t       pal_wr_data;
    logic [32:0] idx_ext;
    logic        idx_ge1;
    logic        idx_ge2;
    logic [31:0] idx_wrap;
    logic        idx_err;
    logic [7:0]  run_rep;
    logic [31:0] pixl_after;
    argb_t       pal_rd_data;

    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign load    = s_fire && result;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bytes_reg     <= 3'd4;
            rle_enable_reg      <= 1'b0;
            indexed_enable_reg  <= 1'b0;
            map_length_reg      <= 16'd0;
            map_entry_bytes_reg <= 3'd3;
            pixel_total_reg     <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PIXEL_BYTES:     pixel_bytes_reg     <= cfg_wdata[2:0];
                REG_RLE_ENABLE:      rle_enable_reg      <= cfg_wdata[0];
                REG_INDEXED_ENABLE:  indexed_enable_reg  <= cfg_wdata[0];
                REG_MAP_LENGTH:      map_length_reg      <= cfg_wdata[15:0];
                REG_MAP_ENTRY_BYTES: map_entry_bytes_reg <= cfg_wdata[2:0];
                REG_PIXEL_TOTAL:     pixel_total_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Start of image clears assembly and packet state and picks the first phase
    // before the byte itself is processed.
    always_comb begin
        if (s_start_of_image) begin
            buf_e   = 24'd0;
            pos_e   = 2'd0;
            pleft_e = 8'd0;
            prun_e  = 1'b0;
            pwi_e   = 16'd0;
            pixl_e  = pixel_total_reg;
            if (map_length_reg != 16'd0) begin
                phase_e = PH_PALETTE;
            end else if (pixel_total_reg != 32'd0) begin
                phase_e = PH_PIXELS;
            end else begin
                phase_e = PH_DONE;
            end
        end else begin
            buf_e   = byte_buffer_reg;
            pos_e   = byte_pos_reg;
            pleft_e = packet_left_reg;
            prun_e  = packet_run_reg;
            pwi_e   = pal_wr_idx_reg;
            pixl_e  = pixels_left_reg;
            phase_e = phase_reg;
        end
    end

    // Byte assembly: shared by palette entries and pixels, count depends on phase.
    assign n_cnt    = (phase_e == PH_PALETTE) ? clamp_count(map_entry_bytes_reg)
                                              : clamp_count(pixel_bytes_reg);
    assign gathered = {8'd0, buf_e} | (32'(s_data_byte) << {pos_e, 3'b000});
    assign complete = ({1'b0, pos_e} + 3'd1) >= n_cnt;

    assign pwi_inc     = pwi_e + 16'd1;
    assign pal_wr_data = to_argb(gathered, n_cnt);

    // Palette index wraps once by map_length; at or beyond twice the map, or past the
    // store, flag it.
    assign idx_ext  = {1'b0, gathered};
    assign idx_ge1  = idx_ext >= {17'd0, map_length_reg};
    assign idx_ge2  = idx_ext >= {16'd0, map_length_reg, 1'b0};
    assign idx_wrap = idx_ge1 ? (gathered - {16'd0, map_length_reg}) : gathered;
    assign idx_err  = idx_ge2 || ({1'b0, idx_wrap} >= 33'(MAP_DEPTH));

    // clip a run to the pixels left
    assign run_rep = (pixl_e < {24'd0, pleft_e}) ? pixl_e[7:0] : pleft_e;

    always_comb begin
        phase_next       = phase_reg;
        byte_buffer_next = byte_buffer_reg;
        byte_pos_next    = byte_pos_reg;
        packet_left_next = packet_left_reg;
        packet_run_next  = packet_run_reg;
        pal_wr_idx_next  = pal_wr_idx_reg;
        pixels_left_next = pixels_left_reg;
        pal_wr_en        = 1'b0;
        result           = 1'b0;
        colour_next      = '0;
        rep_next         = 8'd1;
        err_next         = 1'b0;
        use_pal_next     = 1'b0;
        pixl_after       = pixl_e;
        last_next        = 1'b0;

        if (s_fire) begin
            phase_next       = phase_e;
            byte_buffer_next = buf_e;
            byte_pos_next    = pos_e;
            packet_left_next = pleft_e;
            packet_run_next  = prun_e;
            pal_wr_idx_next  = pwi_e;
            pixels_left_next = pixl_e;

            case (phase_e)
                PH_PALETTE: begin
                    if (complete) begin
                        byte_buffer_next = 24'd0;
                        byte_pos_next    = 2'd0;
                        // drop entries beyond the store
                        pal_wr_en        = {1'b0, pwi_e} < 17'(MAP_DEPTH);
                        pal_wr_idx_next  = pwi_inc;
                        if (pwi_inc >= map_length_reg) begin
                            phase_next = (pixl_e != 32'd0) ? PH_PIXELS : PH_DONE;
                        end
                    end else begin
                        byte_buffer_next = gathered[23:0];
                        byte_pos_next    = pos_e + 2'd1;
                    end
                end
                PH_PIXELS: begin
                    if (rle_enable_reg && pleft_e == 8'd0) begin
                        // packet header
                        packet_run_next  = s_data_byte[7];
                        packet_left_next = {1'b0, s_data_byte[6:0]} + 8'd1;
                    end else if (complete) begin
                        byte_buffer_next = 24'd0;
                        byte_pos_next    = 2'd0;
                        result           = 1'b1;
                        if (indexed_enable_reg) begin
                            err_next     = idx_err;
                            use_pal_next = !idx_err;
                        end else begin
                            colour_next = pal_wr_data;
                        end
                        if (rle_enable_reg && prun_e) begin
                            rep_next         = run_rep;
                            packet_left_next = 8'd0;
                        end else if (rle_enable_reg) begin
                            packet_left_next = pleft_e - 8'd1;
                        end
                        pixl_after       = pixl_e - {24'd0, rep_next};
                        pixels_left_next = pixl_after;
                        last_next        = pixl_after == 32'd0;
                        if (last_next) begin
                            phase_next = PH_DONE;
                        end
                    end else begin
                        byte_buffer_next = gathered[23:0];
                        byte_pos_next    = pos_e + 2'd1;
                    end
                end
                default: begin
                    // done: ignore bytes until the next start of image
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PALETTE;
            byte_buffer_reg <= 24'd0;
            byte_pos_reg    <= 2'd0;
            packet_left_reg <= 8'd0;
            packet_run_reg  <= 1'b0;
            pal_wr_idx_reg  <= 16'd0;
            pixels_left_reg <= 32'd0;
        end else begin
            phase_reg       <= phase_next;
            byte_buffer_reg <= byte_buffer_next;
            byte_pos_reg    <= byte_pos_next;
            packet_left_reg <= packet_left_next;
            packet_run_reg  <= packet_run_next;
            pal_wr_idx_reg  <= pal_wr_idx_next;
            pixels_left_reg <= pixels_left_next;
        end
    end

    // Output register: advance on a new result, drop the word once taken.
    always_comb begin
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            colour_reg  <= colour_next;
            rep_reg     <= rep_next;
            err_reg     <= err_next;
            last_reg    <= last_next;
            use_pal_reg <= use_pal_next;
        end
    end

    // Palette RAM: write during the palette phase, read as the index completes.
    // Its read register loads with the output register, so a stalled word holds.
    tgarle_palette #(
        .DEPTH (MAP_DEPTH),
        .AW    (AW)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr_en),
        .wr_addr (pwi_e[AW-1:0]),
        .wr_data (pal_wr_data),
        .rd_en   (load),
        .rd_addr (idx_wrap[AW-1:0]),
        .rd_data (pal_rd_data)
    );

    assign m_valid        = out_valid_reg;
    assign m_pixel_argb   = use_pal_reg ? pal_rd_data : colour_reg;
    assign m_repeat_count = rep_reg;
    assign m_index_error  = err_reg;
    assign m_last_pixel   = last_reg;

    // A waiting word is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !load)
        else $error("output word overwritten while stalled");

    // Pixel phase always has pixels left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PIXELS) |-> (pixels_left_reg != 32'd0))
        else $error("pixel phase with no pixels left");

    // The last pixel ends the image.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && last_next) |=> (phase_reg == PH_DONE))
        else $error("last pixel did not end the image");

    // Repeat count stays within a packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_count != 8'd0 && m_repeat_count <= 8'd128))
        else $error("repeat count out of range");

    // A bad index gives a zero colour.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_index_error) |-> (m_pixel_argb == 32'd0))
        else $error("index error with nonzero colour");

endmodule
